// ----- rtl/core/banked_register_file_crossbar_assert.svh -----
// assertion macros for the banked register file crossbar
`ifndef BANKED_REGISTER_FILE_CROSSBAR_ASSERT_SVH
`define BANKED_REGISTER_FILE_CROSSBAR_ASSERT_SVH

// same-cycle implication
`define BRFX_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define BRFX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/brfx_pkg.sv -----
// shared types and constants of the banked register file crossbar
package brfx_pkg;

  localparam int LANES     = 4;
  localparam int LANE_W    = 2;
  localparam int BANK_W    = 4;
  localparam int ADDR_W    = 4;
  localparam int WORD_W    = 16;
  localparam int NUM_ROLES = 3;

  localparam int ROLE_SRC0 = 0;
  localparam int ROLE_SRC1 = 1;
  localparam int ROLE_DST  = 2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RED_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RED_ADDRESS = 2'd1;

  localparam logic [ADDR_W-1:0] RED_ADDR_RESET = 4'hF;

  typedef struct packed {
    logic              rd_hit;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
  } brfx_bank_req_t;

endpackage

// ----- rtl/core/banked_register_file_crossbar.sv -----
// top level of the banked register file crossbar
// bank reads are registered at accept; the result enters the output register when stage one advances
// throughput: one word per cycle; input stalls only while both stages hold a word and out_stall is high
// writes land in the bank memories at the accept edge, so the next word reads them
// reset (rst_n low, synchronous) clears handshake state, held port values,
// reduction registers and configuration; bank memories are not cleared
`include "banked_register_file_crossbar_assert.svh"

module banked_register_file_crossbar
  import brfx_pkg::*;
#(
  parameter int NUM_UNITS  = 4,
  parameter int NUM_BANKS  = 8,
  parameter int MATRIX_DIM = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [LANES*BANK_W-1:0] in_src0_banks,
  input  logic [LANES*BANK_W-1:0] in_src1_banks,
  input  logic [LANES*BANK_W-1:0] in_dst_banks,
  input  logic [LANES*ADDR_W-1:0] in_src0_addrs,
  input  logic [LANES*ADDR_W-1:0] in_src1_addrs,
  input  logic [LANES*ADDR_W-1:0] in_dst_read_addrs,
  input  logic [LANES*ADDR_W-1:0] in_dst_write_addrs,
  input  logic [LANES*WORD_W-1:0] in_write_values,
  input  logic                    in_write_enable,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [LANES*WORD_W-1:0] out_src0_values,
  output logic [LANES*WORD_W-1:0] out_src1_values,
  output logic [LANES*WORD_W-1:0] out_dst_read_values,
  output logic [LANES*WORD_W-1:0] out_reduction_values,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [ADDR_W-1:0]       cfg_data
);

  logic                    accept;
  logic                    adv;
  logic                    s1_valid_r;
  logic                    s1_valid_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic                    red_en_r;
  logic [ADDR_W-1:0]       red_addr_r;
  brfx_bank_req_t          req [NUM_BANKS];
  logic                    red_we [LANES];
  logic                    port_ref [NUM_ROLES][LANES];
  logic [BANK_W-1:0]       port_bank [NUM_ROLES][LANES];
  logic                    s1_ref_r [NUM_ROLES][LANES];
  logic [BANK_W-1:0]       s1_bank_r [NUM_ROLES][LANES];
  logic [WORD_W-1:0]       rd_data [NUM_BANKS];
  logic [WORD_W-1:0]       red_r [LANES];
  logic [LANES*WORD_W-1:0] red_pack;
  logic [LANES*WORD_W-1:0] port_val_r [NUM_ROLES];
  logic [LANES*WORD_W-1:0] port_val_nxt [NUM_ROLES];
  logic [LANES*WORD_W-1:0] out_red_r;

  assign in_stall  = s1_valid_r && out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign adv       = s1_valid_r && (!out_valid_r || !out_stall);
  assign cfg_ready = 1'b1;

  assign s1_valid_nxt  = accept || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && out_stall);

  brfx_arb #(
    .NUM_UNITS (NUM_UNITS),
    .NUM_BANKS (NUM_BANKS)
  ) u_arb (
    .src0_banks      (in_src0_banks),
    .src1_banks      (in_src1_banks),
    .dst_banks       (in_dst_banks),
    .src0_addrs      (in_src0_addrs),
    .src1_addrs      (in_src1_addrs),
    .dst_read_addrs  (in_dst_read_addrs),
    .dst_write_addrs (in_dst_write_addrs),
    .write_values    (in_write_values),
    .write_enable    (in_write_enable),
    .red_en          (red_en_r),
    .red_addr        (red_addr_r),
    .req             (req),
    .red_we          (red_we),
    .port_ref        (port_ref),
    .port_bank       (port_bank)
  );

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    brfx_bank #(
      .MATRIX_DIM (MATRIX_DIM)
    ) u_bank (
      .clk     (clk),
      .accept  (accept),
      .req     (req[b]),
      .rd_data (rd_data[b])
    );
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_en_r   <= 1'b0;
      red_addr_r <= RED_ADDR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_RED_ENABLE:  red_en_r   <= cfg_data[0];
        CFG_IDX_RED_ADDRESS: red_addr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // port routing of the word waiting on bank read data
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ref_r  <= port_ref;
      s1_bank_r <= port_bank;
    end
  end

  // reduction registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int u = 0; u < LANES; u++) begin
        red_r[u] <= '0;
      end
    end else if (accept) begin
      for (int u = 0; u < LANES; u++) begin
        if (red_we[u]) begin
          red_r[u] <= in_write_values[WORD_W*u +: WORD_W];
        end
      end
    end
  end

  always_comb begin
    for (int u = 0; u < LANES; u++) begin
      red_pack[WORD_W*u +: WORD_W] = red_r[u];
    end
  end

  // crossbar: referenced ports take their bank's word, others hold
  always_comb begin
    for (int r = 0; r < NUM_ROLES; r++) begin
      port_val_nxt[r] = port_val_r[r];
      for (int u = 0; u < LANES; u++) begin
        if (s1_ref_r[r][u]) begin
          for (int b = 0; b < NUM_BANKS; b++) begin
            if (s1_bank_r[r][u] == BANK_W'(b)) begin
              port_val_nxt[r][WORD_W*u +: WORD_W] = rd_data[b];
            end
          end
        end
      end
    end
  end

  // output register doubles as the held port values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NUM_ROLES; r++) begin
        port_val_r[r] <= '0;
      end
      out_red_r <= '0;
    end else if (adv) begin
      port_val_r <= port_val_nxt;
      out_red_r  <= red_pack;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_src0_values      = port_val_r[ROLE_SRC0];
  assign out_src1_values      = port_val_r[ROLE_SRC1];
  assign out_dst_read_values  = port_val_r[ROLE_DST];
  assign out_reduction_values = out_red_r;

  `BRFX_ASSERT_NOW(a_stall_needs_word, in_stall, s1_valid_r && out_valid_r)
  `BRFX_ASSERT_NEXT(a_accept_fills_stage, accept, s1_valid_r)
  `BRFX_ASSERT_NEXT(a_held_without_advance, !adv, $stable(port_val_r[ROLE_SRC0]))

endmodule

// ----- rtl/core/brfx_bank.sv -----
// one register bank: synchronous memory with one read and one write port
module brfx_bank
  import brfx_pkg::*;
#(
  parameter int MATRIX_DIM = 4
) (
  input  logic              clk,
  input  logic              accept,
  input  brfx_bank_req_t    req,
  output logic [WORD_W-1:0] rd_data
);

  localparam int WORDS = MATRIX_DIM * MATRIX_DIM;
  localparam int DEPTH = (WORDS < 16) ? WORDS : 16;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W:0] DEPTH_L = (ADDR_W + 1)'(DEPTH);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;
  logic              rd_zero_r;
  logic              rd_in;
  logic              wr_in;

  assign rd_in = {1'b0, req.rd_addr} < DEPTH_L;
  assign wr_in = {1'b0, req.wr_addr} < DEPTH_L;

  always_ff @(posedge clk) begin
    if (accept && req.wr_en && wr_in) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req.rd_hit) begin
      rd_zero_r <= !rd_in;
      if (rd_in) begin
        rd_data_r <= mem[req.rd_addr[AW-1:0]];
      end
    end
  end

  assign rd_data = rd_zero_r ? '0 : rd_data_r;

endmodule

// ----- rtl/core/brfx_arb.sv -----
// per-bank read address selection and write arbitration
module brfx_arb
  import brfx_pkg::*;
#(
  parameter int NUM_UNITS = 4,
  parameter int NUM_BANKS = 8
) (
  input  logic [LANES*BANK_W-1:0] src0_banks,
  input  logic [LANES*BANK_W-1:0] src1_banks,
  input  logic [LANES*BANK_W-1:0] dst_banks,
  input  logic [LANES*ADDR_W-1:0] src0_addrs,
  input  logic [LANES*ADDR_W-1:0] src1_addrs,
  input  logic [LANES*ADDR_W-1:0] dst_read_addrs,
  input  logic [LANES*ADDR_W-1:0] dst_write_addrs,
  input  logic [LANES*WORD_W-1:0] write_values,
  input  logic                    write_enable,
  input  logic                    red_en,
  input  logic [ADDR_W-1:0]       red_addr,
  output brfx_bank_req_t          req [NUM_BANKS],
  output logic                    red_we [LANES],
  output logic                    port_ref [NUM_ROLES][LANES],
  output logic [BANK_W-1:0]       port_bank [NUM_ROLES][LANES]
);

  localparam int NU = (NUM_UNITS < LANES) ? NUM_UNITS : LANES;

  logic [LANES*BANK_W-1:0] bank_f [NUM_ROLES];
  logic [LANES*ADDR_W-1:0] addr_f [NUM_ROLES];
  logic                    dst_hit_b [NUM_BANKS];
  logic [LANE_W-1:0]       writer_b [NUM_BANKS];
  logic                    redir_b [NUM_BANKS];

  assign bank_f[ROLE_SRC0] = src0_banks;
  assign bank_f[ROLE_SRC1] = src1_banks;
  assign bank_f[ROLE_DST]  = dst_banks;
  assign addr_f[ROLE_SRC0] = src0_addrs;
  assign addr_f[ROLE_SRC1] = src1_addrs;
  assign addr_f[ROLE_DST]  = dst_read_addrs;

  always_comb begin
    for (int r = 0; r < NUM_ROLES; r++) begin
      for (int u = 0; u < LANES; u++) begin
        port_bank[r][u] = bank_f[r][BANK_W*u +: BANK_W];
        port_ref[r][u]  = (u < NU) && (port_bank[r][u] < BANK_W'(NUM_BANKS));
      end
    end
  end

  // last unit and role naming a bank wins
  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      req[b]       = '0;
      dst_hit_b[b] = 1'b0;
      writer_b[b]  = '0;
      for (int u = 0; u < NU; u++) begin
        for (int r = 0; r < NUM_ROLES; r++) begin
          if (bank_f[r][BANK_W*u +: BANK_W] == BANK_W'(b)) begin
            req[b].rd_hit  = 1'b1;
            req[b].rd_addr = addr_f[r][ADDR_W*u +: ADDR_W];
            if (r == ROLE_DST) begin
              dst_hit_b[b] = 1'b1;
              writer_b[b]  = LANE_W'(u);
            end
          end
        end
      end
      req[b].wr_addr = dst_write_addrs[ADDR_W*writer_b[b] +: ADDR_W];
      req[b].wr_data = write_values[WORD_W*writer_b[b] +: WORD_W];
      redir_b[b]     = red_en && (req[b].wr_addr == red_addr);
      req[b].wr_en   = write_enable && dst_hit_b[b] && !redir_b[b];
    end
    for (int u = 0; u < LANES; u++) begin
      red_we[u] = 1'b0;
      for (int b = 0; b < NUM_BANKS; b++) begin
        if (write_enable && dst_hit_b[b] && redir_b[b] && (writer_b[b] == LANE_W'(u))) begin
          red_we[u] = 1'b1;
        end
      end
    end
  end

endmodule
